### hw/rtl/gpr_pkg.sv
`timescale 1ns / 1ps
package gpr_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  localparam int COORD_W = 10;
  localparam int CODE_W  = 8;
  localparam int COLOR_W = 16;

  localparam int GLYPH_FIRST = 32;
  localparam int GLYPH_LAST  = 90;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 8;
  localparam int GLYPH_IDX_W = 6;
  localparam int GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLED = 2'd0;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_OFF_SCREEN  = 2'd1,
    STATUS_NOT_ENABLED = 2'd2
  } status_t;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;

  // One classified request as it waits between the front and back ends.
  typedef struct packed {
    status_t                status;
    coord_t                 ox;
    coord_t                 oy;
    logic [GLYPH_IDX_W-1:0] glyph;
    color_t                 fg;
    color_t                 bg;
    logic [2:0]             col_last;
    logic [2:0]             row_last;
  } job_t;

  // Bytes are written in the order they are stored, so screen column k of the
  // cell lands at bits [8k+7:8k], and bit 8k+r is row r of that column.
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [GLYPH_IDX_W-1:0] g);
    logic [GLYPH_BITS-1:0] w;
    case (g)
      6'd0:  w = 40'h0000000000;
      6'd1:  w = 40'h00005F0000;
      6'd2:  w = 40'h0007000700;
      6'd3:  w = 40'h147F147F14;
      6'd4:  w = 40'h122A7F2A24;
      6'd5:  w = 40'h6264081323;
      6'd6:  w = 40'h5022554936;
      6'd7:  w = 40'h0000070000;
      6'd8:  w = 40'h0041221C00;
      6'd9:  w = 40'h001C224100;
      6'd10: w = 40'h14083E0814;
      6'd11: w = 40'h08083E0808;
      6'd12: w = 40'h0030500000;
      6'd13: w = 40'h0808080808;
      6'd14: w = 40'h0060600000;
      6'd15: w = 40'h0204081020;
      6'd16: w = 40'h3E4549513E;
      6'd17: w = 40'h00407F4200;
      6'd18: w = 40'h4649516142;
      6'd19: w = 40'h314B454121;
      6'd20: w = 40'h107F121418;
      6'd21: w = 40'h394949492F;
      6'd22: w = 40'h3049494A3C;
      6'd23: w = 40'h070D097101;
      6'd24: w = 40'h3649494936;
      6'd25: w = 40'h1E2949490E;
      6'd26: w = 40'h0036360000;
      6'd27: w = 40'h0036760000;
      6'd28: w = 40'h0041221408;
      6'd29: w = 40'h1414141414;
      6'd30: w = 40'h0814224100;
      6'd31: w = 40'h0609510106;
      6'd32: w = 40'h3E41794932;
      6'd33: w = 40'h7E1111117E;
      6'd34: w = 40'h364949497F;
      6'd35: w = 40'h224141413E;
      6'd36: w = 40'h1C2241417F;
      6'd37: w = 40'h414949497F;
      6'd38: w = 40'h010909097F;
      6'd39: w = 40'h7A4949413E;
      6'd40: w = 40'h7F0808087F;
      6'd41: w = 40'h00417F4100;
      6'd42: w = 40'h013F414020;
      6'd43: w = 40'h412214087F;
      6'd44: w = 40'h404040407F;
      6'd45: w = 40'h7F020C027F;
      6'd46: w = 40'h7F100C027F;
      6'd47: w = 40'h3E4141413E;
      6'd48: w = 40'h060909097F;
      6'd49: w = 40'h5E2151413E;
      6'd50: w = 40'h462919097F;
      6'd51: w = 40'h3149494946;
      6'd52: w = 40'h01017F0101;
      6'd53: w = 40'h3F4040403F;
      6'd54: w = 40'h1F2040201F;
      6'd55: w = 40'h3F4038403F;
      6'd56: w = 40'h6314081463;
      6'd57: w = 40'h0708700807;
      6'd58: w = 40'h4345495161;
      default: w = 40'h0000000000;
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/gpr_if.sv
`timescale 1ns / 1ps
interface gpr_req_if;
  logic           valid;
  logic           ready;
  gpr_pkg::coord_t origin_x;
  gpr_pkg::coord_t origin_y;
  logic [gpr_pkg::CODE_W-1:0] char_code;
  gpr_pkg::color_t fg_color;
  gpr_pkg::color_t back_color;

  modport source (output valid, output origin_x, output origin_y, output char_code,
                  output fg_color, output back_color, input ready);
  modport sink   (input valid, input origin_x, input origin_y, input char_code,
                  input fg_color, input back_color, output ready);
endinterface

interface gpr_pix_if;
  logic           valid;
  logic           ready;
  gpr_pkg::coord_t pixel_x;
  gpr_pkg::coord_t pixel_y;
  gpr_pkg::color_t pixel_rgb;
  logic           last;
  logic [1:0]     status;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_rgb,
                  output last, output status, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_rgb,
                  input last, input status, output ready);
endinterface

### hw/rtl/gpr_cfg.sv
`timescale 1ns / 1ps
module gpr_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gpr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [gpr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [gpr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic                             enabled
);

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == gpr_pkg::REG_ENABLED) begin
      enabled <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == gpr_pkg::REG_ENABLED) begin
      prdata[0] = enabled;
    end
  end

endmodule

### hw/rtl/gpr_front.sv
`timescale 1ns / 1ps
module gpr_front (
  input  logic          enabled,
  gpr_req_if.sink       req,
  output logic          push_valid,
  input  logic          push_ready,
  output gpr_pkg::job_t push_data
);

  logic [10:0] span_x;
  logic [10:0] span_y;
  logic        off_screen;
  logic        in_font;

  assign req.ready  = push_ready;
  assign push_valid = req.valid;

  always_comb begin
    span_x     = 11'(gpr_pkg::SCREEN_WIDTH) - {1'b0, req.origin_x};
    span_y     = 11'(gpr_pkg::SCREEN_HEIGHT) - {1'b0, req.origin_y};
    off_screen = ({1'b0, req.origin_x} >= 11'(gpr_pkg::SCREEN_WIDTH)) ||
                 ({1'b0, req.origin_y} >= 11'(gpr_pkg::SCREEN_HEIGHT));
    in_font    = (req.char_code >= 8'(gpr_pkg::GLYPH_FIRST)) &&
                 (req.char_code <= 8'(gpr_pkg::GLYPH_LAST));

    push_data.ox = req.origin_x;
    push_data.oy = req.origin_y;
    push_data.fg = req.fg_color;
    push_data.bg = req.back_color;
    push_data.glyph = in_font ?
        gpr_pkg::GLYPH_IDX_W'(req.char_code - 8'(gpr_pkg::GLYPH_FIRST)) : '0;
    // Cell is trimmed at the right and bottom edges; spans are at least one when on screen.
    push_data.col_last = (span_x >= 11'(gpr_pkg::GLYPH_COLS)) ? 3'(gpr_pkg::GLYPH_COLS - 1)
                                                             : 3'(span_x[2:0] - 3'd1);
    push_data.row_last = (span_y >= 11'(gpr_pkg::GLYPH_ROWS)) ? 3'(gpr_pkg::GLYPH_ROWS - 1)
                                                             : 3'(span_y[2:0] - 3'd1);

    if (!enabled) begin
      push_data.status = gpr_pkg::STATUS_NOT_ENABLED;
    end else if (off_screen) begin
      push_data.status = gpr_pkg::STATUS_OFF_SCREEN;
    end else begin
      push_data.status = gpr_pkg::STATUS_OK;
    end
  end

endmodule

### hw/rtl/gpr_queue.sv
`timescale 1ns / 1ps
module gpr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  gpr_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output gpr_pkg::job_t pop_data
);

  gpr_pkg::job_t                   slots [gpr_pkg::QUEUE_DEPTH];
  logic [gpr_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [gpr_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [gpr_pkg::QUEUE_PTR_W:0]   count;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (count != (gpr_pkg::QUEUE_PTR_W + 1)'(gpr_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### hw/rtl/gpr_back.sv
`timescale 1ns / 1ps
module gpr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  gpr_pkg::job_t pop_data,
  gpr_pix_if.source     pix
);

  gpr_pkg::job_t                  cur;
  logic [gpr_pkg::GLYPH_BITS-1:0] bits;
  logic                           busy;
  logic [2:0]                     col;
  logic [2:0]                     row;
  logic                           out_valid;

  logic advance;
  logic emit;
  logic fin;
  logic is_error;

  assign advance   = !out_valid || pix.ready;
  assign emit      = busy && advance;
  assign is_error  = (cur.status != gpr_pkg::STATUS_OK);
  assign fin       = is_error || (col == cur.col_last && row == cur.row_last);
  // A new request is loaded in the same cycle the previous one hands over its
  // final pixel, so consecutive requests run without a gap.
  assign pop_ready = !busy || (emit && fin);
  assign pix.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      col       <= '0;
      row       <= '0;
    end else begin
      if (advance) begin
        out_valid <= busy;
      end
      if (pop_valid && pop_ready) begin
        busy <= 1'b1;
        col  <= '0;
        row  <= '0;
      end else if (emit) begin
        if (fin) begin
          busy <= 1'b0;
        end else if (row == cur.row_last) begin
          row <= '0;
          col <= col + 3'd1;
        end else begin
          row <= row + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur  <= pop_data;
      bits <= gpr_pkg::glyph_bits(pop_data.glyph);
    end
    if (emit) begin
      pix.last   <= fin;
      pix.status <= cur.status;
      if (is_error) begin
        pix.pixel_x   <= '0;
        pix.pixel_y   <= '0;
        pix.pixel_rgb <= '0;
      end else begin
        pix.pixel_x   <= cur.ox + gpr_pkg::COORD_W'(col);
        pix.pixel_y   <= cur.oy + gpr_pkg::COORD_W'(row);
        pix.pixel_rgb <= bits[{col, row}] ? cur.fg : cur.bg;
      end
    end
  end

endmodule

### hw/rtl/glyph_pixel_rasterizer_unit.sv
`timescale 1ns / 1ps
// Character cell renderer for a 5x8 bitmap font covering codes 32 to 90.
// A request on req carries the cell origin, the character code and the
// foreground and background RGB565 colors; other codes draw as a space.
// Each request yields one transfer on pix per pixel, column by column and
// top to bottom, trimmed at the right and bottom screen edges, with last set
// on the final pixel. When the display is not enabled, or the origin is off
// screen, a single transfer with an error status and last set is returned.
// The enable bit is written through the APB port at byte address 0.
// A request is stored in the queue, then loaded into the sequencer.
// Throughput: one pixel per cycle while pix is not stalled, so a full glyph is 40
// pixels and an error request one; the back end's pixel sequencer sets this figure.
// A four-entry queue between the request decoder and the sequencer lets new
// requests be taken while pixels of earlier ones are still going out.
// A stall on pix holds the output register and then the sequencer; req stays
// open until the queue fills.
// Reset clears the enable bit, the queue and any request in progress.
module glyph_pixel_rasterizer_unit (
  input  logic                           clk,
  input  logic                           rst,
  gpr_req_if.sink                        req,
  gpr_pix_if.source                      pix,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gpr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gpr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [gpr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic          enabled;
  logic          push_valid;
  logic          push_ready;
  gpr_pkg::job_t push_data;
  logic          pop_valid;
  logic          pop_ready;
  gpr_pkg::job_t pop_data;

  gpr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .enabled (enabled)
  );

  gpr_front u_front (
    .enabled    (enabled),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  gpr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  gpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .pix       (pix)
  );

endmodule

### tb/tb_glyph_pixel_rasterizer_unit.sv
`timescale 1ns / 1ps
module tb_glyph_pixel_rasterizer_unit;

  localparam int unsigned LIMIT_CYCLES = 400000;

  // Font columns packed as the five column bytes in storage order, so screen
  // column k of the cell sits at bits [8k+7:8k] and bit 8k+r is row r.
  localparam logic [39:0] FONT [59] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h122A7F2A24,
    40'h6264081323, 40'h5022554936, 40'h0000070000, 40'h0041221C00, 40'h001C224100,
    40'h14083E0814, 40'h08083E0808, 40'h0030500000, 40'h0808080808, 40'h0060600000,
    40'h0204081020, 40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
    40'h107F121418, 40'h394949492F, 40'h3049494A3C, 40'h070D097101, 40'h3649494936,
    40'h1E2949490E, 40'h0036360000, 40'h0036760000, 40'h0041221408, 40'h1414141414,
    40'h0814224100, 40'h0609510106, 40'h3E41794932, 40'h7E1111117E, 40'h364949497F,
    40'h224141413E, 40'h1C2241417F, 40'h414949497F, 40'h010909097F, 40'h7A4949413E,
    40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F, 40'h404040407F,
    40'h7F020C027F, 40'h7F100C027F, 40'h3E4141413E, 40'h060909097F, 40'h5E2151413E,
    40'h462919097F, 40'h3149494946, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h4345495161
  };

  typedef struct {
    gpr_pkg::coord_t            ox;
    gpr_pkg::coord_t            oy;
    logic [gpr_pkg::CODE_W-1:0] code;
    gpr_pkg::color_t            fg;
    gpr_pkg::color_t            bg;
  } glyph_req_t;

  typedef struct {
    gpr_pkg::coord_t  x;
    gpr_pkg::coord_t  y;
    gpr_pkg::color_t  color;
    logic             last;
    gpr_pkg::status_t status;
  } pixel_t;

  class raster_scoreboard;
    pixel_t      pending_pixels[$];
    int unsigned errors;
    int unsigned requests;
    int unsigned pixels;
    int unsigned off_screen;
    int unsigned refused;

    function void push_error_pixel(gpr_pkg::status_t st);
      pixel_t p;
      p.x = '0;
      p.y = '0;
      p.color = '0;
      p.last = 1'b1;
      p.status = st;
      pending_pixels.push_back(p);
    endfunction

    // Expands one accepted request into the pixels it should produce.
    function void note_request(glyph_req_t r, logic enabled);
      pixel_t      p;
      logic [39:0] cols;
      int          ncols;
      int          nrows;
      int          glyph;
      requests++;
      if (!enabled) begin
        refused++;
        push_error_pixel(gpr_pkg::STATUS_NOT_ENABLED);
      end else if (int'(r.ox) >= gpr_pkg::SCREEN_WIDTH ||
                   int'(r.oy) >= gpr_pkg::SCREEN_HEIGHT) begin
        off_screen++;
        push_error_pixel(gpr_pkg::STATUS_OFF_SCREEN);
      end else begin
        glyph = (int'(r.code) < gpr_pkg::GLYPH_FIRST ||
                 int'(r.code) > gpr_pkg::GLYPH_LAST) ? 0 :
                int'(r.code) - gpr_pkg::GLYPH_FIRST;
        cols = FONT[glyph];
        ncols = gpr_pkg::SCREEN_WIDTH - int'(r.ox);
        if (ncols > gpr_pkg::GLYPH_COLS) ncols = gpr_pkg::GLYPH_COLS;
        nrows = gpr_pkg::SCREEN_HEIGHT - int'(r.oy);
        if (nrows > gpr_pkg::GLYPH_ROWS) nrows = gpr_pkg::GLYPH_ROWS;
        for (int col = 0; col < ncols; col++) begin
          for (int row = 0; row < nrows; row++) begin
            p.x = gpr_pkg::coord_t'(int'(r.ox) + col);
            p.y = gpr_pkg::coord_t'(int'(r.oy) + row);
            p.color = cols[8 * col + row] ? r.fg : r.bg;
            p.last = (col == ncols - 1) && (row == nrows - 1);
            p.status = gpr_pkg::STATUS_OK;
            pending_pixels.push_back(p);
          end
        end
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      pixels++;
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel transfer at x=%0d y=%0d status=%0d",
               got.x, got.y, got.status);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.x !== want.x) begin
        $error("pixel_x: expected %0d, got %0d", want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $error("pixel_y: expected %0d, got %0d", want.y, got.y);
        errors++;
      end
      if (got.color !== want.color) begin
        $error("pixel_rgb: expected %h, got %h", want.color, got.color);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_pixels.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [gpr_pkg::CFG_ADDR_W-1:0] paddr;
  logic [gpr_pkg::CFG_DATA_W-1:0] pwdata;
  logic [gpr_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  gpr_req_if req_bus ();
  gpr_pix_if pix_bus ();

  glyph_pixel_rasterizer_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .pix     (pix_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  raster_scoreboard sb = new();
  logic       enabled_model = 1'b0;
  logic       steady = 1'b0;
  int         sink_hold = 0;
  glyph_req_t seen_req;
  pixel_t     seen_pix;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("timeout with %0d pixels still expected", sb.outstanding());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Both channels and the register port are observed at the clock edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (psel && penable && pwrite && pready && paddr == gpr_pkg::REG_ENABLED)
        enabled_model <= pwdata[0];
      if (req_bus.valid && req_bus.ready) begin
        seen_req.ox = req_bus.origin_x;
        seen_req.oy = req_bus.origin_y;
        seen_req.code = req_bus.char_code;
        seen_req.fg = req_bus.fg_color;
        seen_req.bg = req_bus.back_color;
        sb.note_request(seen_req, enabled_model);
      end
      if (pix_bus.valid && pix_bus.ready) begin
        seen_pix.x = pix_bus.pixel_x;
        seen_pix.y = pix_bus.pixel_y;
        seen_pix.color = pix_bus.pixel_rgb;
        seen_pix.last = pix_bus.last;
        seen_pix.status = gpr_pkg::status_t'(pix_bus.status);
        sb.check_pixel(seen_pix);
      end
    end
  end

  // Pixel sink: short random stalls, none started while steady is set.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      pix_bus.ready <= 1'b0;
    end else if (!steady && $urandom_range(99) < 2) begin
      sink_hold <= $urandom_range(4);
      pix_bus.ready <= 1'b0;
    end else begin
      pix_bus.ready <= 1'b1;
    end
  end

  function automatic glyph_req_t mk_req(int ox, int oy, int code, int fg, int bg);
    glyph_req_t r;
    r.ox = gpr_pkg::coord_t'(ox);
    r.oy = gpr_pkg::coord_t'(oy);
    r.code = gpr_pkg::CODE_W'(code);
    r.fg = gpr_pkg::color_t'(fg);
    r.bg = gpr_pkg::color_t'(bg);
    return r;
  endfunction

  function automatic glyph_req_t random_request();
    glyph_req_t  r;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) begin
      r.ox = gpr_pkg::coord_t'($urandom_range(gpr_pkg::SCREEN_WIDTH - 1));
      r.oy = gpr_pkg::coord_t'($urandom_range(gpr_pkg::SCREEN_HEIGHT - 1));
    end else if (sel < 80) begin
      // Cells near or across the right or bottom edge, or both.
      r.ox = gpr_pkg::coord_t'($urandom_range(gpr_pkg::SCREEN_WIDTH - 1,
                                              gpr_pkg::SCREEN_WIDTH - 8));
      r.oy = gpr_pkg::coord_t'($urandom_range(gpr_pkg::SCREEN_HEIGHT - 1,
                                              gpr_pkg::SCREEN_HEIGHT - 10));
      if ($urandom_range(2) == 0)
        r.ox = gpr_pkg::coord_t'($urandom_range(gpr_pkg::SCREEN_WIDTH - 9));
      else if ($urandom_range(1) == 0)
        r.oy = gpr_pkg::coord_t'($urandom_range(gpr_pkg::SCREEN_HEIGHT - 11));
    end else if (sel < 90) begin
      r.ox = gpr_pkg::coord_t'($urandom_range(1023));
      r.oy = gpr_pkg::coord_t'($urandom_range(1023));
    end else begin
      r.ox = gpr_pkg::coord_t'($urandom_range(gpr_pkg::SCREEN_WIDTH - 1));
      r.oy = gpr_pkg::coord_t'($urandom_range(gpr_pkg::SCREEN_HEIGHT - 1));
      if ($urandom_range(1) == 0)
        r.ox = gpr_pkg::coord_t'(gpr_pkg::SCREEN_WIDTH + $urandom_range(2));
      else
        r.oy = gpr_pkg::coord_t'(gpr_pkg::SCREEN_HEIGHT + $urandom_range(2));
    end
    if ($urandom_range(99) < 75)
      r.code = gpr_pkg::CODE_W'($urandom_range(gpr_pkg::GLYPH_LAST, gpr_pkg::GLYPH_FIRST));
    else
      r.code = gpr_pkg::CODE_W'($urandom_range(255));
    r.fg = gpr_pkg::color_t'($urandom);
    r.bg = gpr_pkg::color_t'($urandom);
    return r;
  endfunction

  // Called at a clock edge; returns at the edge where the request is taken.
  task automatic send_request(input glyph_req_t r);
    if (!steady && $urandom_range(99) < 6) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.origin_x <= r.ox;
    req_bus.origin_y <= r.oy;
    req_bus.char_code <= r.code;
    req_bus.fg_color <= r.fg;
    req_bus.back_color <= r.bg;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // Stops sending and waits until every expected pixel has been seen.
  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic write_enabled(input logic en);
    logic [gpr_pkg::CFG_DATA_W-1:0] data;
    data = $urandom;
    data[0] = en;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= gpr_pkg::REG_ENABLED;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int count;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_bus.valid <= 1'b0;
    req_bus.origin_x <= '0;
    req_bus.origin_y <= '0;
    req_bus.char_code <= '0;
    req_bus.fg_color <= '0;
    req_bus.back_color <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out of reset the display is off, which wins over an off-screen origin.
    send_request(mk_req(0, 0, "A", 'hFFFF, 'h0000));
    send_request(mk_req(1023, 1023, "Z", 'h1234, 'h4321));
    send_request(mk_req(319, 239, 0, 'hFFFF, 'hFFFF));
    drain();
    write_enabled(1'b1);

    send_request(mk_req(0, 0, "A", 'hFFFF, 'h0000));
    send_request(mk_req(10, 20, gpr_pkg::GLYPH_FIRST, 'h1234, 'hABCD));
    send_request(mk_req(30, 20, gpr_pkg::GLYPH_LAST, 'h5555, 'hAAAA));
    send_request(mk_req(40, 20, gpr_pkg::GLYPH_FIRST - 1, 'hAAAA, 'h5555));
    send_request(mk_req(50, 20, gpr_pkg::GLYPH_LAST + 1, 'h0F0F, 'hF0F0));
    send_request(mk_req(60, 20, 0, 'h8001, 'h7FFE));
    send_request(mk_req(70, 20, 255, 'h00FF, 'hFF00));
    // Right and bottom clipping, down to a single pixel in the corner, then off-screen origins.
    send_request(mk_req(315, 100, "#", 'hF800, 'h07E0));
    send_request(mk_req(316, 100, "M", 'h001F, 'hFFE0));
    send_request(mk_req(319, 100, "W", 'h07FF, 'hF81F));
    send_request(mk_req(100, 232, "$", 'hC618, 'h39E7));
    send_request(mk_req(100, 233, "&", 'h1111, 'hEEEE));
    send_request(mk_req(100, 239, "8", 'h2222, 'hDDDD));
    send_request(mk_req(319, 239, "@", 'hFFFF, 'h0000));
    send_request(mk_req(gpr_pkg::SCREEN_WIDTH, 0, "A", 'hFFFF, 'h0000));
    send_request(mk_req(0, gpr_pkg::SCREEN_HEIGHT, "A", 'hFFFF, 'h0000));
    send_request(mk_req(1023, 1023, "A", 'hFFFF, 'hFFFF));
    send_request(mk_req(1023, 0, "B", 'h0000, 'h0000));
    send_request(mk_req(0, 1023, "C", 'hFFFF, 'hFFFF));
    send_request(mk_req(200, 200, "B", 'h0000, 'hFFFF));
    drain();
    write_enabled(1'b0);
    send_request(mk_req(5, 5, "Q", 'hFFFF, 'h0000));
    send_request(mk_req(320, 240, "Q", 'hFFFF, 'h0000));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_enabled(ph != 3);
      steady <= (ph == 1);
      count = (ph == 3) ? 15 : 60;
      for (int i = 0; i < count; i++) begin
        // Now and then hold off until the pixel stream has gone quiet.
        if ($urandom_range(99) < 2) drain();
        send_request(random_request());
      end
    end

    drain();
    repeat (16) @(posedge clk);
    $display("Rendered %0d requests into %0d pixel transfers: %0d refused while disabled,",
             sb.requests, sb.pixels, sb.refused);
    $display("%0d with the origin off screen, edge clipping and stalls on both channels.",
             sb.off_screen);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
